[rtl/core/kcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock core.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Digits per code group (1 to 16)
    localparam int CODE_LENGTH = 4;
    localparam int CNT_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CODE_LENGTH - 1);

    localparam int KEY_W   = 4;
    localparam int LIMIT_W = 4;
    localparam int TICKS_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd5000;
    localparam logic [LIMIT_W-1:0] FAIL_MAX    = 4'd15;

    // Configuration register indexes
    localparam logic CFG_ATTEMPT_LIMIT = 1'b0;
    localparam logic CFG_LOCKOUT_TICKS = 1'b1;

    // Input op codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        MODE_ENROLL   = 4'b0001,
        MODE_ACCESS   = 4'b0010,
        MODE_UNLOCKED = 4'b0100,
        MODE_LOCKOUT  = 4'b1000
    } kcl_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DIGIT    = 3'd1,
        ST_ENROLLED = 3'd2,
        ST_GRANTED  = 3'd3,
        ST_DENIED   = 3'd4,
        ST_LOCKED   = 3'd5,
        ST_OVER     = 3'd6,
        ST_IGNORED  = 3'd7
    } kcl_status_t;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key_value;
    } kcl_in_t;

    typedef struct packed {
        kcl_status_t  status;
        logic [2:0]   digits_entered;
        logic [3:0]   attempts_left;
        logic         unlocked;
        logic         locked_out;
    } kcl_out_t;

    // Digit write request from the controller to the digit store
    typedef struct packed {
        logic             secret_we;
        logic             entry_we;
        logic [CNT_W-1:0] index;
        logic [KEY_W-1:0] key;
    } kcl_dig_wr_t;

endpackage

[rtl/core/keypad_code_lock_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_core
// Code lock controller: enrolls a secret, checks entered groups, counts
// failures and runs a tick-driven lockout.
// ----------------------------------------------------------------------------
//  channel  | ports                          | carries
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid, s_ready, s_data       | key press or tick
//  result   | m_valid, m_ready, m_data       | one status record per item
//  config   | cfg_we, cfg_index, cfg_wdata   | attempt limit, lockout ticks
//
//  One item per cycle while m_ready takes each result; the result shows in the cycle after its transfer.
//  State updates and the result register load in the same edge.
//  s_ready is low only while a result waits and m_ready is low.
//  aresetn clears mode, counts and config; digit registers keep no reset.
// ----------------------------------------------------------------------------
module keypad_code_lock_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  kcl_pkg::kcl_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output kcl_pkg::kcl_out_t           m_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]   cfg_wdata
);

    logic [kcl_pkg::LIMIT_W-1:0] limit_reg;
    logic [kcl_pkg::TICKS_W-1:0] ticks_reg;
    logic                        m_valid_reg;
    kcl_pkg::kcl_out_t           m_data_reg;
    kcl_pkg::kcl_out_t           result;
    kcl_pkg::kcl_dig_wr_t        dig_wr;
    logic                        match;
    logic                        fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= kcl_pkg::LIMIT_RESET;
            ticks_reg <= kcl_pkg::TICKS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kcl_pkg::CFG_ATTEMPT_LIMIT: limit_reg <= cfg_wdata[kcl_pkg::LIMIT_W-1:0];
                kcl_pkg::CFG_LOCKOUT_TICKS: ticks_reg <= cfg_wdata[kcl_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    kcl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (s_data),
        .attempt_limit (limit_reg),
        .lockout_ticks (ticks_reg),
        .match         (match),
        .wr            (dig_wr),
        .result        (result)
    );

    kcl_digit_store u_digits (
        .aclk  (aclk),
        .wr    (dig_wr),
        .match (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Assertions
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("transfer without a following result");

    a_lamps_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.unlocked && m_data.locked_out))
        else $error("unlocked and locked out together");

    a_granted_unlocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == kcl_pkg::ST_GRANTED) |-> m_data.unlocked)
        else $error("grant without unlock");

    a_locked_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == kcl_pkg::ST_LOCKED) |-> m_data.locked_out)
        else $error("lockout status without lockout");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.digits_entered < 3'(kcl_pkg::CODE_LENGTH)
                     || kcl_pkg::CODE_LENGTH > 7))
        else $error("digit count out of range");

endmodule

[rtl/core/kcl_digit_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_digit_store
// Secret and entry digit registers with the whole-group compare.
// ----------------------------------------------------------------------------
module kcl_digit_store (
    input  logic                 aclk,
    input  kcl_pkg::kcl_dig_wr_t wr,
    output logic                 match
);

    logic [kcl_pkg::KEY_W-1:0] secret_reg [kcl_pkg::CODE_LENGTH];
    logic [kcl_pkg::KEY_W-1:0] entry_reg  [kcl_pkg::CODE_LENGTH];
    logic [kcl_pkg::CODE_LENGTH-1:0] eq;

    always_ff @(posedge aclk) begin
        if (wr.secret_we) begin
            secret_reg[wr.index] <= wr.key;
        end
        if (wr.entry_we) begin
            entry_reg[wr.index] <= wr.key;
        end
    end

    // The last digit of a group is the key arriving now, not yet stored
    for (genvar g = 0; g < kcl_pkg::CODE_LENGTH - 1; g++) begin : g_eq
        assign eq[g] = (entry_reg[g] == secret_reg[g]);
    end
    assign eq[kcl_pkg::CODE_LENGTH-1] = (wr.key == secret_reg[kcl_pkg::LAST_IDX]);

    assign match = &eq;

endmodule

[rtl/core/kcl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_ctrl
// Lock mode machine, digit count, failure count and lockout countdown.
// ----------------------------------------------------------------------------
module kcl_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  kcl_pkg::kcl_in_t              item,
    input  logic [kcl_pkg::LIMIT_W-1:0]   attempt_limit,
    input  logic [kcl_pkg::TICKS_W-1:0]   lockout_ticks,
    input  logic                          match,
    output kcl_pkg::kcl_dig_wr_t          wr,
    output kcl_pkg::kcl_out_t             result
);

    kcl_pkg::kcl_mode_t              mode_reg, mode_next;
    logic [kcl_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [kcl_pkg::LIMIT_W-1:0]     fail_reg, fail_next;
    logic [kcl_pkg::TICKS_W-1:0]     remain_reg, remain_next;
    logic [kcl_pkg::LIMIT_W-1:0]     fail_inc;
    kcl_pkg::kcl_status_t            status;
    logic                            is_key;
    logic                            last_digit;

    assign is_key     = (item.op == kcl_pkg::OP_KEY);
    assign last_digit = (cnt_reg == kcl_pkg::LAST_IDX);
    assign fail_inc   = (fail_reg == kcl_pkg::FAIL_MAX) ? fail_reg
                                                        : fail_reg + 4'd1;

    always_comb begin
        mode_next    = mode_reg;
        cnt_next     = cnt_reg;
        fail_next    = fail_reg;
        remain_next  = remain_reg;
        status       = kcl_pkg::ST_IDLE;
        wr.secret_we = 1'b0;
        wr.entry_we  = 1'b0;
        wr.index     = cnt_reg;
        wr.key       = item.key_value;

        unique case (mode_reg)
            kcl_pkg::MODE_ENROLL: begin
                if (is_key) begin
                    wr.secret_we = fire;
                    if (last_digit) begin
                        cnt_next  = '0;
                        mode_next = kcl_pkg::MODE_ACCESS;
                        status    = kcl_pkg::ST_ENROLLED;
                    end else begin
                        cnt_next = cnt_reg + kcl_pkg::CNT_W'(1);
                        status   = kcl_pkg::ST_DIGIT;
                    end
                end
            end
            kcl_pkg::MODE_ACCESS: begin
                if (is_key) begin
                    wr.entry_we = fire;
                    if (!last_digit) begin
                        cnt_next = cnt_reg + kcl_pkg::CNT_W'(1);
                        status   = kcl_pkg::ST_DIGIT;
                    end else begin
                        cnt_next = '0;
                        if (match) begin
                            mode_next = kcl_pkg::MODE_UNLOCKED;
                            status    = kcl_pkg::ST_GRANTED;
                        end else begin
                            fail_next = fail_inc;
                            if (fail_inc >= attempt_limit) begin
                                mode_next   = kcl_pkg::MODE_LOCKOUT;
                                remain_next = lockout_ticks;
                                status      = kcl_pkg::ST_LOCKED;
                            end else begin
                                status = kcl_pkg::ST_DENIED;
                            end
                        end
                    end
                end
            end
            kcl_pkg::MODE_UNLOCKED: begin
                if (is_key) begin
                    status = kcl_pkg::ST_IGNORED;
                end
            end
            kcl_pkg::MODE_LOCKOUT: begin
                if (is_key) begin
                    status = kcl_pkg::ST_IGNORED;
                end else if (remain_reg <= 16'd1) begin
                    // zero-length lockout ends on its first tick
                    remain_next = '0;
                    fail_next   = '0;
                    mode_next   = kcl_pkg::MODE_ACCESS;
                    status      = kcl_pkg::ST_OVER;
                end else begin
                    remain_next = remain_reg - 16'd1;
                    status      = kcl_pkg::ST_LOCKED;
                end
            end
            default: begin
                mode_next = kcl_pkg::MODE_ENROLL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= kcl_pkg::MODE_ENROLL;
            cnt_reg    <= '0;
            fail_reg   <= '0;
            remain_reg <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            fail_reg   <= fail_next;
            remain_reg <= remain_next;
        end
    end

    always_comb begin
        result.status         = status;
        result.digits_entered = 3'(cnt_next);
        result.attempts_left  = (attempt_limit > fail_next) ? attempt_limit - fail_next
                                                            : 4'd0;
        result.unlocked       = (mode_next == kcl_pkg::MODE_UNLOCKED);
        result.locked_out     = (mode_next == kcl_pkg::MODE_LOCKOUT);
    end

endmodule
